// ----- rtl/qrs_pkg.sv -----
// Shared types, widths and status codes of the quadratic root solver.
package qrs_pkg;

  localparam int COEFF_W     = 16;
  localparam int FRAC_BITS   = 8;
  localparam int DISC_W      = 34;
  localparam int ROOT_W      = 17;
  localparam int X_W         = 25;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int NUM_W       = ROOT_W + 2;
  localparam int MAG_W       = NUM_W - 1;
  localparam int DVS_W       = COEFF_W + 2;
  localparam int DVD_W       = MAG_W + FRAC_BITS + 1;
  localparam int IN_W        = 3 * COEFF_W;
  localparam int OUT_RAW_W   = 2 + DISC_W + ROOT_W + 2 * X_W;
  localparam int OUT_W       = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_TWO_ROOTS  = 2'd0,
    ST_NEG_DISC   = 2'd1,
    ST_NOT_SQUARE = 2'd2,
    ST_A_ZERO     = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] a;
    logic signed [COEFF_W-1:0] b;
    logic signed [DISC_W-1:0]  disc;
  } job_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DISC_W-1:0] disc;
    logic [ROOT_W-1:0]        root;
    logic                     neg_m;
    logic                     neg_p;
  } tag_t;

endpackage

// ----- rtl/qrs_disc.sv -----
// Two-stage discriminant computation: products, then b*b - 4ac.
module qrs_disc
  import qrs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [COEFF_W-1:0] a,
  input  logic signed [COEFF_W-1:0] b,
  input  logic signed [COEFF_W-1:0] c,
  output logic                      out_valid,
  output job_t                      out_job
);

  logic                        v1_r, v2_r;
  logic signed [COEFF_W-1:0]   a1_r, b1_r;
  logic signed [2*COEFF_W-1:0] bb_r, ac_r;
  job_t                        job_r;
  logic signed [DISC_W-1:0]    disc_nxt;

  assign disc_nxt = DISC_W'(bb_r) - (DISC_W'(ac_r) <<< 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r       <= a;
      b1_r       <= b;
      bb_r       <= b * b;
      ac_r       <= a * c;
      job_r.a    <= a1_r;
      job_r.b    <= b1_r;
      job_r.disc <= disc_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_job   = job_r;

endmodule

// ----- rtl/qrs_sqrt.sv -----
// Pipelined digit-by-digit square root, one result bit per stage.
module qrs_sqrt
  import qrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  job_t              in_job,
  output logic              out_valid,
  output job_t              out_job,
  output logic [ROOT_W-1:0] out_root,
  output logic              out_exact
);

  localparam int REM_W = ROOT_W + 1;

  logic              v_r   [SQRT_STAGES];
  job_t              job_r [SQRT_STAGES];
  logic [REM_W-1:0]  rem_r [SQRT_STAGES];
  logic [ROOT_W-1:0] res_r [SQRT_STAGES];
  logic [DISC_W-1:0] dv_r  [SQRT_STAGES];

  logic [REM_W-1:0]  rem_nxt [SQRT_STAGES];
  logic [ROOT_W-1:0] res_nxt [SQRT_STAGES];
  logic [DISC_W-1:0] dv_nxt  [SQRT_STAGES];

  always_comb begin
    logic [REM_W-1:0]  src_rem;
    logic [ROOT_W-1:0] src_res;
    logic [DISC_W-1:0] src_dv;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        src_rem = '0;
        src_res = '0;
        src_dv  = in_job.disc;
      end else begin
        src_rem = rem_r[k-1];
        src_res = res_r[k-1];
        src_dv  = dv_r[k-1];
      end
      cur   = {src_rem, src_dv[DISC_W-1 -: 2]};
      trial = (REM_W+2)'({src_res, 2'b01});
      diff  = cur - trial;
      if (cur >= trial) begin
        rem_nxt[k] = diff[REM_W-1:0];
        res_nxt[k] = {src_res[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = cur[REM_W-1:0];
        res_nxt[k] = {src_res[ROOT_W-2:0], 1'b0};
      end
      dv_nxt[k] = {src_dv[DISC_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STAGES; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < SQRT_STAGES; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job_r[0] <= in_job;
      for (int k = 1; k < SQRT_STAGES; k++) job_r[k] <= job_r[k-1];
      for (int k = 0; k < SQRT_STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        res_r[k] <= res_nxt[k];
        dv_r[k]  <= dv_nxt[k];
      end
    end
  end

  assign out_valid = v_r[SQRT_STAGES-1];
  assign out_job   = job_r[SQRT_STAGES-1];
  assign out_root  = res_r[SQRT_STAGES-1];
  assign out_exact = (rem_r[SQRT_STAGES-1] == '0);

endmodule

// ----- rtl/qrs_div.sv -----
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
module qrs_div
  import qrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  tag_t             in_tag,
  input  logic [DVD_W-1:0] dvd_m,
  input  logic [DVD_W-1:0] dvd_p,
  input  logic [DVS_W-1:0] dvs,
  output logic             out_valid,
  output tag_t             out_tag,
  output logic [DVD_W-1:0] quo_m,
  output logic [DVD_W-1:0] quo_p
);

  typedef struct packed {
    logic [DVS_W-1:0] rem;
    logic [DVD_W-1:0] num;
    logic [DVD_W-1:0] quo;
  } lane_t;

  function automatic lane_t div_step(lane_t src, logic [DVS_W-1:0] d);
    lane_t            res;
    logic [DVS_W:0]   cur;
    logic [DVS_W:0]   diff;
    cur  = {src.rem, src.num[DVD_W-1]};
    diff = cur - {1'b0, d};
    if (cur >= {1'b0, d}) begin
      res.rem = diff[DVS_W-1:0];
      res.quo = {src.quo[DVD_W-2:0], 1'b1};
    end else begin
      res.rem = cur[DVS_W-1:0];
      res.quo = {src.quo[DVD_W-2:0], 1'b0};
    end
    res.num = {src.num[DVD_W-2:0], 1'b0};
    return res;
  endfunction

  logic             v_r   [DVD_W];
  tag_t             tag_r [DVD_W];
  logic [DVS_W-1:0] dvs_r [DVD_W];
  lane_t            lm_r  [DVD_W];
  lane_t            lp_r  [DVD_W];
  lane_t            lm_nxt [DVD_W];
  lane_t            lp_nxt [DVD_W];

  always_comb begin
    lane_t src_m;
    lane_t src_p;
    for (int k = 0; k < DVD_W; k++) begin
      if (k == 0) begin
        src_m = '{rem: '0, num: dvd_m, quo: '0};
        src_p = '{rem: '0, num: dvd_p, quo: '0};
        lm_nxt[k] = div_step(src_m, dvs);
        lp_nxt[k] = div_step(src_p, dvs);
      end else begin
        lm_nxt[k] = div_step(lm_r[k-1], dvs_r[k-1]);
        lp_nxt[k] = div_step(lp_r[k-1], dvs_r[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DVD_W; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < DVD_W; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      dvs_r[0] <= dvs;
      for (int k = 1; k < DVD_W; k++) begin
        tag_r[k] <= tag_r[k-1];
        dvs_r[k] <= dvs_r[k-1];
      end
      for (int k = 0; k < DVD_W; k++) begin
        lm_r[k] <= lm_nxt[k];
        lp_r[k] <= lp_nxt[k];
      end
    end
  end

  assign out_valid = v_r[DVD_W-1];
  assign out_tag   = tag_r[DVD_W-1];
  assign quo_m     = lm_r[DVD_W-1].quo;
  assign quo_p     = lp_r[DVD_W-1].quo;

endmodule

// ----- rtl/quadratic_root_solver_unit.sv -----
// Quadratic root solver: discriminant, exact square root and two fixed-point roots.
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds while a result waits at the output register.
// Reset: synchronous active-low rst_n clears all stage valid bits; data is not reset.
module quadratic_root_solver_unit
  import qrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // coeff_a [15:0], coeff_b [31:16], coeff_c [47:32]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // solve_status [1:0], discriminant [35:2], disc_root [52:36],
  // root_minus [77:53], root_plus [102:78], zero pad above
  output logic [OUT_W-1:0] out_tdata
);

  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(1) << (X_W - 1);
  localparam logic [DVD_W-1:0] POS_LIM = NEG_LIM - DVD_W'(1);

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic disc_v;
  job_t disc_job;

  qrs_disc u_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .a        (in_tdata[COEFF_W-1:0]),
    .b        (in_tdata[2*COEFF_W-1:COEFF_W]),
    .c        (in_tdata[3*COEFF_W-1:2*COEFF_W]),
    .out_valid(disc_v),
    .out_job  (disc_job)
  );

  logic              sq_v;
  job_t              sq_job;
  logic [ROOT_W-1:0] sq_root;
  logic              sq_exact;

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (disc_v),
    .in_job   (disc_job),
    .out_valid(sq_v),
    .out_job  (sq_job),
    .out_root (sq_root),
    .out_exact(sq_exact)
  );

  // Operand preparation: signs, magnitudes and the rounding-biased dividends.
  logic signed [NUM_W-1:0] num_m, num_p;
  logic signed [COEFF_W:0] den;
  logic [MAG_W-1:0]        mag_m, mag_p;
  logic [COEFF_W:0]        mag_d;
  status_t                 status;
  tag_t                    tag_nxt;

  always_comb begin
    num_m = -(NUM_W'(sq_job.b) + $signed(NUM_W'(sq_root)));
    num_p = $signed(NUM_W'(sq_root)) - NUM_W'(sq_job.b);
    den   = {sq_job.a, 1'b0};
    mag_m = num_m[NUM_W-1] ? MAG_W'(-num_m) : MAG_W'(num_m);
    mag_p = num_p[NUM_W-1] ? MAG_W'(-num_p) : MAG_W'(num_p);
    mag_d = den[COEFF_W] ? (COEFF_W+1)'(-den) : den;
    if (sq_job.a == '0) begin
      status = ST_A_ZERO;
    end else if (sq_job.disc[DISC_W-1]) begin
      status = ST_NEG_DISC;
    end else if (!sq_exact) begin
      status = ST_NOT_SQUARE;
    end else begin
      status = ST_TWO_ROOTS;
    end
    tag_nxt.status = status;
    tag_nxt.disc   = sq_job.disc;
    tag_nxt.root   = (status == ST_TWO_ROOTS) ? sq_root : '0;
    tag_nxt.neg_m  = num_m[NUM_W-1] ^ den[COEFF_W];
    tag_nxt.neg_p  = num_p[NUM_W-1] ^ den[COEFF_W];
  end

  logic             prep_v_r;
  tag_t             prep_tag_r;
  logic [DVD_W-1:0] prep_dm_r, prep_dp_r;
  logic [DVS_W-1:0] prep_dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else if (en) begin
      prep_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_tag_r <= tag_nxt;
      prep_dm_r  <= (DVD_W'(mag_m) << (FRAC_BITS + 1)) + DVD_W'(mag_d);
      prep_dp_r  <= (DVD_W'(mag_p) << (FRAC_BITS + 1)) + DVD_W'(mag_d);
      prep_dvs_r <= {mag_d, 1'b0};
    end
  end

  logic             dv_v;
  tag_t             dv_tag;
  logic [DVD_W-1:0] q_m, q_p;

  qrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (prep_v_r),
    .in_tag   (prep_tag_r),
    .dvd_m    (prep_dm_r),
    .dvd_p    (prep_dp_r),
    .dvs      (prep_dvs_r),
    .out_valid(dv_v),
    .out_tag  (dv_tag),
    .quo_m    (q_m),
    .quo_p    (q_p)
  );

  function automatic logic [X_W-1:0] fix_sat(logic [DVD_W-1:0] q, logic neg);
    logic [DVD_W-1:0] nq;
    nq = -q;
    if (neg) begin
      return (q > NEG_LIM) ? NEG_LIM[X_W-1:0] : nq[X_W-1:0];
    end
    return (q > POS_LIM) ? POS_LIM[X_W-1:0] : q[X_W-1:0];
  endfunction

  logic [X_W-1:0] xm, xp;
  assign xm = (dv_tag.status == ST_TWO_ROOTS) ? fix_sat(q_m, dv_tag.neg_m) : '0;
  assign xp = (dv_tag.status == ST_TWO_ROOTS) ? fix_sat(q_p, dv_tag.neg_p) : '0;

  logic             out_v_r;
  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OUT_W'({xp, xm, dv_tag.root, dv_tag.disc, dv_tag.status});
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // A non-zero status never carries a root.
  a_no_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_TWO_ROOTS) |->
      out_tdata[OUT_RAW_W-1:2+DISC_W] == '0)
    else $error("roots present with failing status");

  // With status zero the square root is exact.
  a_exact_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_TWO_ROOTS) |->
      (DISC_W'(out_tdata[2+DISC_W+ROOT_W-1:2+DISC_W]) *
       DISC_W'(out_tdata[2+DISC_W+ROOT_W-1:2+DISC_W])) == out_tdata[2+DISC_W-1:2])
    else $error("disc_root squared differs from discriminant");

  // A negative discriminant status must match the sign of the discriminant.
  a_neg_disc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_NEG_DISC) |-> out_tdata[2+DISC_W-1])
    else $error("negative discriminant status with nonnegative discriminant");

endmodule
